// ===== hw/rtl/quadrature_position_speed_unit_assert.svh =====
// Assertion macros shared by the quadrature position/speed RTL.
// Used inside modules that have clk and rst in scope.
`ifndef QUADRATURE_POSITION_SPEED_UNIT_ASSERT_SVH
`define QUADRATURE_POSITION_SPEED_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QPS_CHECK(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define QPS_CHECK_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/qps_pkg.sv =====
// Package for the quadrature position/speed unit: sizes, payload structs,
// sequencer states, step decode and speed saturation. No dependencies.
package qps_pkg;

  localparam int NUM_ENCODERS = 3;
  localparam int COUNT_BITS   = 32;
  localparam int IDX_W        = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int FRAC_BITS    = 16;
  localparam int DIV_W        = COUNT_BITS + FRAC_BITS;
  localparam int TIME_W       = 32;

  localparam logic CMD_PIN  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        enc_index;
    logic              pin_a;
    logic              pin_b;
    logic [TIME_W-1:0] time_us;
  } qps_req_t;

  typedef struct packed {
    logic [1:0]         out_index;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic               zero_interval;
    logic               last;
  } qps_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIN,
    S_START,
    S_WAIT,
    S_EMIT
  } qps_state_t;

  // Gray-code step from {old A, old B, new A, new B}.
  function automatic logic signed [1:0] step_of(input logic [3:0] sum);
    logic signed [1:0] st;
    unique case (sum) inside
      4'b0010, 4'b0100, 4'b1011, 4'b1101: st = 2'sb01;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: st = 2'sb11;
      default:                            st = 2'sb00;
    endcase
    return st;
  endfunction

  // Clamp a quotient magnitude to signed 32 bits and apply the sign.
  function automatic logic [31:0] sat_speed(input logic [DIV_W-1:0] q, input logic neg);
    logic [63:0] qx;
    logic [31:0] r;
    qx = 64'(q);
    if (!neg) begin
      r = (qx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qx[31:0];
    end else begin
      r = (qx > 64'h8000_0000) ? 32'h8000_0000 : (~qx[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qps_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on qps_pkg for widths and request/response structs.
module qps_div
  import qps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [DIV_W-1:0]  num;

  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign shifted = {rem, num[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      num <= req.dividend;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      num <= {num[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

// ===== hw/rtl/quadrature_position_speed_unit.sv =====
// Top level of the quadrature position/speed unit: encoder state, sequencer,
// output register. Depends on qps_pkg, qps_div and the assertion macro header.
//
//  channel | signals                     | moves
//  --------+-----------------------------+-------------------------------------
//  request | req_valid, req_stall, req   | pin sample or speed tick, in
//  result  | rsp_valid, rsp_stall, rsp   | position/speed per encoder, out
//
//  Pin sample: the transfer moves the sequencer to S_PIN, which loads the
//  result once the output register is free of a stalled result; the sequencer
//  then returns to S_IDLE, where the next request can transfer. Speed tick:
//  one result per encoder, in order; a nonzero elapsed time runs the shared
//  divider, one quotient bit per cycle; a zero elapsed time skips the divider.
//  req_stall is high from a transfer until its last result is loaded; a result
//  can wait in the output register while the next request transfers.
//  Synchronous reset clears all counts, pin states and the tick timestamp.
`include "quadrature_position_speed_unit_assert.svh"

module quadrature_position_speed_unit
  import qps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  qps_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output qps_rsp_t rsp
);

  // Architectural state
  logic [1:0]            last_pins     [NUM_ENCODERS];
  logic [COUNT_BITS-1:0] count         [NUM_ENCODERS];
  logic [COUNT_BITS-1:0] count_at_tick [NUM_ENCODERS];
  logic [TIME_W-1:0]     tick_time;

  // Sequencer and work registers
  qps_state_t        state, state_next;
  logic [IDX_W-1:0]  cur;
  logic [1:0]        pin_now;
  logic [TIME_W-1:0] dt;
  logic              neg;
  logic [31:0]       speed;

  logic     accept;
  logic     out_free;
  logic     out_load;
  logic     div_start;
  logic     tick_last;
  logic     dt_zero;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Per-item datapath
  logic signed [1:0]            step;
  logic [COUNT_BITS-1:0]        count_new;
  logic [COUNT_BITS-1:0]        delta;
  logic [COUNT_BITS-1:0]        mag;
  logic signed [COUNT_BITS-1:0] pos_src;
  qps_rsp_t                     rsp_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign tick_last = (32'(cur) == NUM_ENCODERS - 1);
  assign dt_zero   = (dt == '0);

  assign step      = step_of({last_pins[cur], pin_now});
  assign count_new = count[cur] + COUNT_BITS'(step);

  // count change since last tick, wrapped, as sign and magnitude
  assign delta = count[cur] - count_at_tick[cur];
  assign mag   = delta[COUNT_BITS-1] ? (~delta + COUNT_BITS'(1)) : delta;

  assign div_req.start    = div_start;
  assign div_req.dividend = {mag, FRAC_BITS'(0)};
  assign div_req.divisor  = dt;

  qps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.cmd == CMD_TICK) ? S_START : S_PIN;
        end
      end
      S_PIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_START: begin
        if (dt_zero) begin
          state_next = S_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = tick_last ? S_IDLE : S_START;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result assembly
  always_comb begin
    pos_src = (state == S_PIN) ? count_new : count[cur];
    rsp_next.out_index     = 2'(cur);
    rsp_next.position      = 32'(pos_src);
    rsp_next.speed         = (state == S_PIN) ? '0 : speed;
    rsp_next.zero_interval = (state == S_PIN) ? 1'b0 : dt_zero;
    rsp_next.last          = (state == S_PIN) ? 1'b1 : tick_last;
  end

  // Encoder state and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        last_pins[i]     <= '0;
        count[i]         <= '0;
        count_at_tick[i] <= '0;
      end
      tick_time <= '0;
      cur       <= '0;
      dt        <= '0;
    end else begin
      if (accept) begin
        if (req.cmd == CMD_TICK) begin
          dt        <= req.time_us - tick_time;
          tick_time <= req.time_us;
          cur       <= '0;
        end else begin
          // out-of-range index folds onto the last encoder
          cur <= (32'(req.enc_index) >= NUM_ENCODERS) ? IDX_W'(NUM_ENCODERS - 1)
                                                       : IDX_W'(req.enc_index);
        end
      end
      if (out_load && state == S_PIN) begin
        count[cur]     <= count_new;
        last_pins[cur] <= pin_now;
      end
      if (out_load && state == S_EMIT) begin
        count_at_tick[cur] <= count[cur];
        if (!tick_last) begin
          cur <= cur + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_now <= {req.pin_a, req.pin_b};
    end
    if (state == S_START) begin
      neg   <= delta[COUNT_BITS-1];
      speed <= '0;
    end
    if (state == S_WAIT && div_rsp.done) begin
      speed <= sat_speed(div_rsp.quotient, neg);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  `QPS_CHECK(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide by zero started")
  `QPS_CHECK_NEXT(a_done_emit, div_rsp.done, state == S_EMIT, "quotient not taken")
  `QPS_CHECK_NEXT(a_last_idle, out_load && rsp_next.last, state == S_IDLE, "last not ending")
  `QPS_CHECK(a_zero_speed, rsp_valid && rsp.zero_interval, rsp.speed == '0, "zero dt speed")

endmodule
